// File: hdl/dkrb_pkg.sv
// Shared types and constants for the debounced keyboard report builder.
// Used by every module under hdl/; depends on nothing.
package dkrb_pkg;

  localparam int RAW_BUTTONS      = 14;
  localparam int COUNT_W          = 3;
  localparam int KEY_W            = 8;
  localparam int MAX_SLOTS        = 6;
  localparam int LO_W             = 64;
  localparam int HI_W             = 48;
  localparam int CFG_W            = 64;
  localparam int CFG_IDX_W        = 2;
  localparam int IN_W             = 16;
  localparam int OUT_W            = 72;

  localparam int BUTTONS_DEF      = 14;
  localparam int FILTER_LIMIT_DEF = 4;
  localparam int KEY_SLOTS_DEF    = 6;

  // keycodes 0xE0..0xE7 are modifier keys
  localparam logic [4:0] MOD_KEY_PREFIX = 5'b11100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEYCODES_LO  = 2'd0,
    REG_KEYCODES_HI  = 2'd1,
    REG_MODIFIERS_LO = 2'd2,
    REG_MODIFIERS_HI = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [HI_W-1:0] mm_hi;
    logic [LO_W-1:0] mm_lo;
    logic [HI_W-1:0] kc_hi;
    logic [LO_W-1:0] kc_lo;
  } key_map_t;

  // mods in the low byte, then slot 0 upward
  typedef struct packed {
    logic [MAX_SLOTS-1:0][KEY_W-1:0] keys;
    logic [KEY_W-1:0]                mods;
  } report_t;

endpackage

// File: hdl/dkrb_debounce.sv
// Per-button integrating debounce counters and latched pressed state.
// Depends on dkrb_pkg.
module dkrb_debounce #(
  parameter int BUTTONS      = dkrb_pkg::BUTTONS_DEF,
  parameter int FILTER_LIMIT = dkrb_pkg::FILTER_LIMIT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  logic [dkrb_pkg::RAW_BUTTONS-1:0] raw,
  output logic [BUTTONS-1:0]               latched_next
);

  localparam logic [dkrb_pkg::COUNT_W-1:0] LIMIT = dkrb_pkg::COUNT_W'(FILTER_LIMIT);

  logic [dkrb_pkg::COUNT_W-1:0] counts      [BUTTONS];
  logic [dkrb_pkg::COUNT_W-1:0] counts_next [BUTTONS];
  logic [BUTTONS-1:0]           latched;
  logic [BUTTONS-1:0]           pressed;

  genvar b;
  generate
    for (b = 0; b < BUTTONS; b++) begin : g_btn
      if (b < dkrb_pkg::RAW_BUTTONS) begin : g_raw
        assign pressed[b] = raw[b];
      end else begin : g_none
        assign pressed[b] = 1'b0;
      end

      always_comb begin
        counts_next[b] = counts[b];
        if (pressed[b] && counts[b] < LIMIT) begin
          counts_next[b] = counts[b] + 1'b1;
        end else if (!pressed[b] && counts[b] != '0) begin
          counts_next[b] = counts[b] - 1'b1;
        end
        latched_next[b] = latched[b];
        if (!latched[b] && counts_next[b] == LIMIT) begin
          latched_next[b] = 1'b1;
        end else if (latched[b] && counts_next[b] == '0) begin
          latched_next[b] = 1'b0;
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          counts[b]  <= '0;
          latched[b] <= 1'b0;
        end else if (step) begin
          counts[b]  <= counts_next[b];
          latched[b] <= latched_next[b];
        end
      end
    end
  endgenerate

endmodule

// File: hdl/dkrb_report.sv
// Builds the modifier byte and compacted key slots from the latched buttons.
// Pure logic; depends on dkrb_pkg.
module dkrb_report #(
  parameter int BUTTONS   = dkrb_pkg::BUTTONS_DEF,
  parameter int KEY_SLOTS = dkrb_pkg::KEY_SLOTS_DEF
) (
  input  logic [BUTTONS-1:0]  latched,
  input  dkrb_pkg::key_map_t  key_map,
  output dkrb_pkg::report_t   report
);

  localparam int RANK_W = $clog2(BUTTONS + 1);

  logic [dkrb_pkg::KEY_W-1:0] kc    [BUTTONS];
  logic [dkrb_pkg::KEY_W-1:0] mm    [BUTTONS];
  logic [dkrb_pkg::KEY_W-1:0] mod_contrib [BUTTONS];
  logic [RANK_W-1:0]          rank  [BUTTONS];
  logic [BUTTONS-1:0]         ordinary;

  genvar b;
  generate
    for (b = 0; b < BUTTONS; b++) begin : g_btn
      localparam logic [BUTTONS-1:0] BELOW = BUTTONS'((17'd1 << b) - 17'd1);
      logic live;
      logic mod_key;

      if (b < 8) begin : g_lo
        assign kc[b] = key_map.kc_lo[8*b +: 8];
        assign mm[b] = key_map.mm_lo[8*b +: 8];
      end else if (b < dkrb_pkg::RAW_BUTTONS) begin : g_hi
        assign kc[b] = key_map.kc_hi[8*(b-8) +: 8];
        assign mm[b] = key_map.mm_hi[8*(b-8) +: 8];
      end else begin : g_none
        assign kc[b] = '0;
        assign mm[b] = '0;
      end

      // a zero keycode contributes nothing, not even its mask
      assign live        = latched[b] && (kc[b] != '0);
      assign mod_key     = (kc[b][7:3] == dkrb_pkg::MOD_KEY_PREFIX);
      assign ordinary[b] = live && !mod_key;
      assign mod_contrib[b] = !live ? '0 :
                              (mm[b] | (mod_key ? (8'd1 << kc[b][2:0]) : 8'd0));
      // slot position = ordinary keys on lower buttons
      assign rank[b] = RANK_W'($countones(ordinary & BELOW));
    end
  endgenerate

  always_comb begin
    report = '0;
    for (int i = 0; i < BUTTONS; i++) begin
      report.mods = report.mods | mod_contrib[i];
    end
    for (int j = 0; j < KEY_SLOTS; j++) begin
      for (int i = 0; i < BUTTONS; i++) begin
        if (ordinary[i] && rank[i] == RANK_W'(j)) begin
          report.keys[j] = report.keys[j] | kc[i];
        end
      end
    end
  end

endmodule

// File: hdl/debounced_keyboard_report_builder.sv
// Top level: input register, config registers, debounce, report, output register.
// Depends on dkrb_pkg, dkrb_debounce and dkrb_report.
//
// One scan tick per word on s_axis; a word is accepted every cycle while the
// output side keeps up. A tick's result reaches the output register through the
// input register: the tick is held in the input register, then debounce
// update, report build and emit decision run in one pass into the output
// register. Ticks that yield no report leave no word on m_axis. When
// the output word is not taken, the input register takes at most one more
// tick and s_axis_tready then stays low until the word is taken. The keycode
// and modifier tables are written through
// cfg_we/cfg_index/cfg_data (0: keycodes 0-7, 1: keycodes 8-13, 2: modifiers
// 0-7, 3: modifiers 8-13, one byte per button, lowest button lowest).
module debounced_keyboard_report_builder #(
  parameter int BUTTONS      = dkrb_pkg::BUTTONS_DEF,
  parameter int FILTER_LIMIT = dkrb_pkg::FILTER_LIMIT_DEF,
  parameter int KEY_SLOTS    = dkrb_pkg::KEY_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // raw_levels[13:0], endpoint_ready[14], zero[15]
  input  logic [dkrb_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // modifier_byte[7:0], key_one..key_six[55:8], debounced_buttons[69:56], zero[71:70]
  output logic [dkrb_pkg::OUT_W-1:0]     m_axis_tdata,
  input  logic                           cfg_we,
  input  logic [dkrb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dkrb_pkg::CFG_W-1:0]     cfg_data
);

  localparam int RB = dkrb_pkg::RAW_BUTTONS;

  dkrb_pkg::key_map_t key_map;

  logic                  in_valid;
  logic [RB-1:0]         in_raw;
  logic                  in_ep_ready;
  logic                  advance;
  logic                  out_free;

  logic [BUTTONS-1:0]    latched_next;
  logic [RB-1:0]         deb;
  dkrb_pkg::report_t     report;
  logic                  nonempty;
  logic                  emit;
  logic                  active;
  logic                  active_next;

  logic                  out_valid;
  dkrb_pkg::report_t     out_report;
  logic [RB-1:0]         out_deb;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_map <= '0;
    end else if (cfg_we) begin
      case (dkrb_pkg::cfg_reg_t'(cfg_index))
        dkrb_pkg::REG_KEYCODES_LO:  key_map.kc_lo <= cfg_data;
        dkrb_pkg::REG_KEYCODES_HI:  key_map.kc_hi <= cfg_data[dkrb_pkg::HI_W-1:0];
        dkrb_pkg::REG_MODIFIERS_LO: key_map.mm_lo <= cfg_data;
        dkrb_pkg::REG_MODIFIERS_HI: key_map.mm_hi <= cfg_data[dkrb_pkg::HI_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free      = !out_valid || m_axis_tready;
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_raw      <= s_axis_tdata[RB-1:0];
      in_ep_ready <= s_axis_tdata[RB];
    end
  end

  dkrb_debounce #(
    .BUTTONS      (BUTTONS),
    .FILTER_LIMIT (FILTER_LIMIT)
  ) u_debounce (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .raw          (in_raw),
    .latched_next (latched_next)
  );

  dkrb_report #(
    .BUTTONS   (BUTTONS),
    .KEY_SLOTS (KEY_SLOTS)
  ) u_report (
    .latched (latched_next),
    .key_map (key_map),
    .report  (report)
  );

  genvar b;
  generate
    for (b = 0; b < RB; b++) begin : g_deb
      if (b < BUTTONS) begin : g_on
        assign deb[b] = latched_next[b];
      end else begin : g_off
        assign deb[b] = 1'b0;
      end
    end
  endgenerate

  // empty report goes out while active; active drops only once the host is ready
  assign nonempty = (report.mods != '0) || (report.keys[0] != '0);
  assign emit     = nonempty || active;

  always_comb begin
    active_next = active;
    if (nonempty) begin
      active_next = 1'b1;
    end else if (active && in_ep_ready) begin
      active_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (advance) begin
      active <= active_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (out_valid && !m_axis_tready) || (advance && emit);
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_report <= report;
      out_deb    <= deb;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_deb, out_report};

  // an empty first slot means every slot is empty
  a_slots_compact: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_report.keys[0] == '0) |-> (out_report.keys == '0))
    else $error("key slots not compacted");

  // an empty report is only loaded while the keyboard is active
  a_empty_needs_active: assert property (@(posedge clk) disable iff (rst)
    (advance && emit && !nonempty) |-> active)
    else $error("empty report while idle");

  // active only rises from a non-empty report
  a_active_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(active) |-> ($past(advance) && $past(nonempty)))
    else $error("active set without a report");

endmodule

// File: tb/debounced_keyboard_report_builder_test.sv
// Self-checking testbench for debounced_keyboard_report_builder: scan ticks in,
// HID reports out, compared against a cycle-free model of debounce and report logic.
// Depends on dkrb_pkg and the RTL under hdl/.

// One predicted or observed report: debounced state above the report bytes,
// same layout as m_axis_tdata[69:0].
typedef struct packed {
  logic [dkrb_pkg::RAW_BUTTONS-1:0] buttons;
  dkrb_pkg::report_t                rep;
} tick_result_t;

class report_scoreboard;
  dkrb_pkg::key_map_t                  key_map;
  logic [dkrb_pkg::COUNT_W-1:0]        filter_count [dkrb_pkg::BUTTONS_DEF];
  logic [dkrb_pkg::BUTTONS_DEF-1:0]    held;
  bit                                  active;
  tick_result_t                        awaited_reports[$];
  int                                  ticks;
  int                                  reports;
  int                                  failures;

  function new();
    key_map = '0;
    foreach (filter_count[b]) filter_count[b] = '0;
    held = '0;
    active = 1'b0;
    ticks = 0;
    reports = 0;
    failures = 0;
  endfunction

  function void load(dkrb_pkg::key_map_t m);
    key_map = m;
  endfunction

  function int pending();
    return awaited_reports.size();
  endfunction

  function logic [7:0] table_byte(logic [63:0] lo, logic [47:0] hi, int b);
    if (b < 8) return lo[8*b +: 8];
    return hi[8*(b-8) +: 8];
  endfunction

  // Advance debounce state by one scan tick and queue the report it yields.
  function void note_tick(logic [13:0] raw, logic ready);
    tick_result_t r;
    logic [7:0]   code;
    logic [7:0]   mask;
    int           used;
    r = '0;
    used = 0;
    ticks++;
    for (int b = 0; b < dkrb_pkg::BUTTONS_DEF; b++) begin
      if (raw[b]) begin
        if (filter_count[b] < dkrb_pkg::FILTER_LIMIT_DEF) filter_count[b]++;
      end else if (filter_count[b] != 0) begin
        filter_count[b]--;
      end
      if (!held[b] && filter_count[b] == dkrb_pkg::FILTER_LIMIT_DEF) held[b] = 1'b1;
      else if (held[b] && filter_count[b] == 0) held[b] = 1'b0;
    end
    for (int b = 0; b < dkrb_pkg::BUTTONS_DEF; b++) begin
      if (!held[b]) continue;
      code = table_byte(key_map.kc_lo, key_map.kc_hi, b);
      if (code == 8'h00) continue;
      mask = table_byte(key_map.mm_lo, key_map.mm_hi, b);
      r.rep.mods |= mask;
      if (code >= 8'hE0 && code <= 8'hE7) begin
        r.rep.mods |= 8'(1 << code[2:0]);
      end else if (used < dkrb_pkg::KEY_SLOTS_DEF) begin
        r.rep.keys[used] = code;
        used++;
      end
    end
    if (r.rep.mods != 0 || r.rep.keys[0] != 0) begin
      active = 1'b1;
    end else if (active) begin
      if (ready) active = 1'b0;
    end else begin
      return;
    end
    r.buttons = held;
    awaited_reports.push_back(r);
  endfunction

  function void flag(string what, logic [69:0] want, logic [69:0] got);
    failures++;
    if (failures <= 10) $display("mismatch in %s: expected %0h, got %0h", what, want, got);
  endfunction

  function void check_report(logic [71:0] word);
    tick_result_t got;
    tick_result_t want;
    got = word[69:0];
    reports++;
    if (awaited_reports.size() == 0) begin
      flag("unrequested report", '0, got);
      return;
    end
    want = awaited_reports.pop_front();
    if (got.rep.mods !== want.rep.mods) flag("modifier byte", want.rep.mods, got.rep.mods);
    for (int k = 0; k < dkrb_pkg::MAX_SLOTS; k++)
      if (got.rep.keys[k] !== want.rep.keys[k])
        flag($sformatf("key slot %0d", k), want.rep.keys[k], got.rep.keys[k]);
    if (got.buttons !== want.buttons) flag("debounced buttons", want.buttons, got.buttons);
  endfunction
endclass

module debounced_keyboard_report_builder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES    = 8;
  localparam int PHASES          = 6;
  localparam int TICKS_PER_PHASE = 84;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [dkrb_pkg::IN_W-1:0]      s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [dkrb_pkg::OUT_W-1:0]     m_axis_tdata;
  logic                           cfg_we = 1'b0;
  logic [dkrb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dkrb_pkg::CFG_W-1:0]     cfg_data = '0;

  report_scoreboard board = new();

  logic [31:0] rx_pattern = '1;
  logic [4:0]  rx_pos = '0;
  int          burst_left = 0;
  bit          gaps_on = 1'b0;
  int          settings_used = 0;

  always #1 clk = ~clk;

  debounced_keyboard_report_builder DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // receiver backpressure follows a rotating per-phase pattern
  always @(negedge clk) begin
    m_axis_tready <= rx_pattern[rx_pos];
    rx_pos <= rx_pos + 1'b1;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_report(m_axis_tdata);
  end

  task automatic send_tick(logic [13:0] raw, logic ready);
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {1'b0, ready, raw};
    do @(posedge clk); while (!s_axis_tready);
    board.note_tick(raw, ready);
  endtask

  task automatic pause_sender(int cycles);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    s_axis_tdata = dkrb_pkg::IN_W'($urandom);
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) pause_sender($urandom_range(1, 8));
    end
    burst_left--;
  endtask

  // stop sending until every queued report has come back, plus pipeline slack
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // 48-bit tables get junk in the upper word bits; the block must drop them
  task automatic load_key_map(dkrb_pkg::key_map_t m);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = dkrb_pkg::REG_KEYCODES_LO;
    cfg_data = m.kc_lo;
    @(negedge clk);
    cfg_index = dkrb_pkg::REG_KEYCODES_HI;
    cfg_data = {16'($urandom), m.kc_hi};
    @(negedge clk);
    cfg_index = dkrb_pkg::REG_MODIFIERS_LO;
    cfg_data = m.mm_lo;
    @(negedge clk);
    cfg_index = dkrb_pkg::REG_MODIFIERS_HI;
    cfg_data = {16'($urandom), m.mm_hi};
    @(negedge clk);
    cfg_we = 1'b0;
    board.load(m);
    settings_used++;
  endtask

  function automatic dkrb_pkg::key_map_t random_key_map();
    dkrb_pkg::key_map_t m;
    logic [7:0]         code;
    logic [7:0]         mask;
    m = '0;
    for (int b = 0; b < dkrb_pkg::RAW_BUTTONS; b++) begin
      case ($urandom_range(0, 9))
        0, 1:    code = 8'h00;
        2, 3:    code = {dkrb_pkg::MOD_KEY_PREFIX, 3'($urandom_range(0, 7))};
        default: code = 8'($urandom_range(1, 255));
      endcase
      mask = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom);
      if (b < 8) begin
        m.kc_lo[8*b +: 8] = code;
        m.mm_lo[8*b +: 8] = mask;
      end else begin
        m.kc_hi[8*(b-8) +: 8] = code;
        m.mm_hi[8*(b-8) +: 8] = mask;
      end
    end
    return m;
  endfunction

  initial begin
    dkrb_pkg::key_map_t m;
    logic [13:0]        held_set;
    logic [13:0]        raw;
    int                 hold_ticks;
    held_set = '0;
    hold_ticks = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zero keycode with a mask, modifier keycodes, slot overflow,
    // empty report repeating while the endpoint is busy, then going idle.
    m.kc_lo = 64'h0A09_0807_0605_0400;
    m.kc_hi = 48'hFF_E7_E5_E3_E0_0B;
    m.mm_lo = 64'h0000_0000_0000_0180;
    m.mm_hi = 48'h10_0000_0000_00;
    load_key_map(m);
    repeat (4) send_tick(14'h3FFF, 1'b1);
    repeat (5) send_tick(14'h0000, 1'b0);
    repeat (3) send_tick(14'h0000, 1'b1);
    repeat (4) send_tick(14'h0001, 1'b1);
    repeat (4) send_tick(14'h0000, 1'b1);
    wait_drained();

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) m = '0;
      else if (phase == 1) m = '1;
      else m = random_key_map();
      load_key_map(m);
      rx_pattern = (phase % 3 == 0) ? '1 : ($urandom | 32'h1);
      gaps_on = phase[0];
      burst_left = 0;
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        if (n == TICKS_PER_PHASE / 2 && phase[0]) wait_drained();
        if (hold_ticks == 0) begin
          case ($urandom_range(0, 3))
            0: held_set = '0;
            1: held_set = 14'(1 << $urandom_range(0, 13));
            2: held_set = 14'($urandom & $urandom);
            default: held_set = 14'($urandom);
          endcase
          hold_ticks = $urandom_range(1, 9);
        end
        hold_ticks--;
        raw = held_set;
        case ($urandom_range(0, 7))
          0: raw ^= 14'(1 << $urandom_range(0, 13));   // contact bounce
          1: raw = 14'($urandom);
          default: ;
        endcase
        pace();
        send_tick(raw, $urandom_range(0, 3) != 0);
      end
      wait_drained();
    end

    $display("%0d scan ticks sent under %0d key tables, %0d reports checked",
             board.ticks, settings_used, board.reports);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d reports never seen", board.failures, board.pending());
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #500_000;
    $display("timeout with %0d reports outstanding", board.pending());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
